// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, constants and helpers of the priority tick scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int SLOT_W   = 6;
    localparam int TIME_W   = 12;
    localparam int PRIO_W   = 4;
    localparam int WIDE_W   = 16;
    localparam int PCOUNT_W = 7;
    localparam int CFG_IDX_W = 1;

    // one tick in 12.4 fixed point
    localparam logic [WIDE_W-1:0] ONE_TICK = 16'd16;

    // command modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIM_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

    localparam logic [WIDE_W-1:0] SIM_LENGTH_RST    = 16'd100;
    localparam logic [PCOUNT_W-1:0] ENTRY_COUNT_RST = 7'd50;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] run_time;
        logic [PRIO_W-1:0] priority_req;
    } pts_cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] running_slot;
        logic              idle;
        logic              finished;
        logic [WIDE_W-1:0] turnaround;
        logic [WIDE_W-1:0] finish_tick;
        logic              run_ended;
    } pts_result_t;

    // one process table entry as held in memory
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
        logic [WIDE_W-1:0] wait_acc;
        logic              done;
    } pts_entry_t;

    localparam int ENTRY_W = $bits(pts_entry_t);

    function automatic logic [WIDE_W-1:0] sat_add16(input logic [WIDE_W-1:0] a,
                                                    input logic [WIDE_W-1:0] b);
        logic [WIDE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[WIDE_W] ? {WIDE_W{1'b1}} : sum[WIDE_W-1:0];
    endfunction

    // entry with one more tick of wait
    function automatic pts_entry_t add_wait(input pts_entry_t e);
        pts_entry_t r;
        r = e;
        r.wait_acc = sat_add16(e.wait_acc, ONE_TICK);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/preemptive_priority_tick_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_tick_scheduler
// preemptive highest-priority-first scheduler stepped one tick per command
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one process entry. A tick word (mode 1)
// walks the process table once through a single memory read port, one
// entry per cycle, over n entries where n is min(entry count,
// MAX_PROCESSES); busy stays high for the pass and its finish step. After
// the run has ended a tick word is answered in the next cycle without a
// pass. Every tick word gives exactly one result word on result, marked by
// result_valid for one cycle; the receiver cannot hold it off. Load words
// give no result. Configuration writes are taken whenever the block is not
// busy.
// ----------------------------------------------------------------------------
module preemptive_priority_tick_scheduler #(
    parameter int MAX_PROCESSES = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire pts_pkg::pts_cmd_t                cmd,
    output pts_pkg::pts_result_t                  result,
    output logic                                  result_valid,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pts_pkg::WIDE_W-1:0]       cfg_data
);

    import pts_pkg::*;

    // table address and entry count widths
    localparam int AW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNTW = $clog2(MAX_PROCESSES + 1);
    localparam int PW   = (CNTW > PCOUNT_W) ? CNTW : PCOUNT_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNTW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                rv_reg, rv_next;          // read data valid this cycle
    logic [AW-1:0]       ridx_reg, ridx_next;      // entry of the read data
    logic                lv_reg, lv_next;          // that entry was ever loaded
    logic                found_reg, found_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    pts_entry_t          best_reg, best_next;
    logic [WIDE_W-1:0]   tick_reg, tick_next;
    logic                ended_reg, ended_next;
    logic [WIDE_W-1:0]   sim_length_reg, sim_length_next;
    logic [PCOUNT_W-1:0] pcount_reg, pcount_next;
    pts_result_t         result_reg, result_next;
    logic                result_valid_reg, result_valid_next;
    logic [MAX_PROCESSES-1:0] loaded_reg, loaded_next;

    // memory port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                accept;
    logic                slot_ok;
    logic [CNTW-1:0]     n_eff;
    pts_entry_t          cur;
    pts_entry_t          load_entry;
    pts_entry_t          fin_entry;
    logic                eligible;
    logic                take;
    logic                fin;
    logic [WIDE_W:0]     trn_sum;

    pts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && !busy;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // entries beyond the table size are dropped on load
    assign slot_ok = (int'(cmd.slot) < MAX_PROCESSES);

    // process count clamped to the table size
    assign n_eff = (PW'(pcount_reg) > PW'(MAX_PROCESSES)) ? CNTW'(MAX_PROCESSES)
                                                          : CNTW'(pcount_reg);

    always_comb
    begin
        load_entry           = '0;
        load_entry.arrival   = cmd.arrival;
        load_entry.run_time  = cmd.run_time;
        load_entry.remaining = cmd.run_time;
        load_entry.prio      = cmd.priority_req;
    end

    // a never loaded entry reads as all zero
    assign cur = lv_reg ? pts_entry_t'(ram_rdata) : '0;

    // arrived strictly before this tick and not yet complete
    assign eligible = !cur.done &&
                      ({{(WIDE_W + 4 - TIME_W){1'b0}}, cur.arrival} < {tick_reg, 4'b0000});
    // strict compare keeps the lowest slot on a priority tie
    assign take = eligible && (!found_reg || (cur.prio < best_reg.prio));

    // completion of the selected process at the end of the pass
    assign fin     = found_reg && (best_reg.remaining <= ONE_TICK[TIME_W-1:0]);
    assign trn_sum = {{(WIDE_W + 1 - TIME_W){1'b0}}, best_reg.run_time}
                     + {1'b0, best_reg.wait_acc};

    always_comb
    begin
        fin_entry           = best_reg;
        fin_entry.remaining = fin ? '0 : best_reg.remaining - ONE_TICK[TIME_W-1:0];
        fin_entry.done      = fin;
    end

    // memory read and write selection
    always_comb
    begin
        ram_re    = (state_reg == S_SCAN) && (rd_cnt_reg < n_eff);
        ram_raddr = rd_cnt_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.mode == MODE_LOAD) && slot_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(cmd.slot);
                    ram_wdata = load_entry;
                end
            end
            S_SCAN:
            begin
                // one wait update per entry: either the entry just read, or
                // the best so far when the entry just read displaces it
                if (rv_reg && eligible)
                begin
                    if (!take)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ridx_reg;
                        ram_wdata = add_wait(cur);
                    end
                    else if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = add_wait(best_reg);
                    end
                end
            end
            S_FINISH:
            begin
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = fin_entry;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer and datapath
    always_comb
    begin
        state_next        = state_reg;
        rd_cnt_next       = rd_cnt_reg;
        rv_next           = 1'b0;
        ridx_next         = ridx_reg;
        lv_next           = lv_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_next         = best_reg;
        tick_next         = tick_reg;
        ended_next        = ended_reg;
        sim_length_next   = sim_length_reg;
        pcount_next       = pcount_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        loaded_next       = loaded_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SIM_LENGTH:  sim_length_next = cfg_data;
                REG_ENTRY_COUNT: pcount_next     = cfg_data[PCOUNT_W-1:0];
                default:         sim_length_next = sim_length_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == MODE_LOAD)
                    begin
                        if (slot_ok)
                        begin
                            loaded_next[AW'(cmd.slot)] = 1'b1;
                        end
                    end
                    else if (ended_reg)
                    begin
                        // run over: answer at once, state untouched
                        result_next           = '0;
                        result_next.idle      = 1'b1;
                        result_next.run_ended = 1'b1;
                        result_valid_next     = 1'b1;
                    end
                    else
                    begin
                        rd_cnt_next = '0;
                        found_next  = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (ram_re)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rv_next     = 1'b1;
                    ridx_next   = rd_cnt_reg[AW-1:0];
                    lv_next     = loaded_reg[rd_cnt_reg[AW-1:0]];
                end
                if (rv_reg && take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = ridx_reg;
                    best_next     = cur;
                end
                if (!ram_re && !rv_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                result_next = '0;
                if (!found_reg)
                begin
                    result_next.idle = 1'b1;
                end
                else
                begin
                    result_next.running_slot = SLOT_W'(best_idx_reg);
                    if (fin)
                    begin
                        result_next.finished    = 1'b1;
                        result_next.turnaround  = trn_sum[WIDE_W] ? {WIDE_W{1'b1}}
                                                                  : trn_sum[WIDE_W-1:0];
                        result_next.finish_tick = tick_reg;
                        if (tick_reg >= sim_length_reg)
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
                result_next.run_ended = ended_next;
                result_valid_next     = 1'b1;
                if (tick_reg != {WIDE_W{1'b1}})
                begin
                    tick_next = tick_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rd_cnt_reg       <= '0;
            rv_reg           <= 1'b0;
            found_reg        <= 1'b0;
            tick_reg         <= '0;
            ended_reg        <= 1'b0;
            sim_length_reg   <= SIM_LENGTH_RST;
            pcount_reg       <= ENTRY_COUNT_RST;
            result_valid_reg <= 1'b0;
            loaded_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_cnt_reg       <= rd_cnt_next;
            rv_reg           <= rv_next;
            found_reg        <= found_next;
            tick_reg         <= tick_next;
            ended_reg        <= ended_next;
            sim_length_reg   <= sim_length_next;
            pcount_reg       <= pcount_next;
            result_valid_reg <= result_valid_next;
            loaded_reg       <= loaded_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        ridx_reg     <= ridx_next;
        lv_reg       <= lv_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        result_reg   <= result_next;
    end

    // a result word follows a finished pass or a tick after the run ended
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg == S_FINISH) ||
                          $past(accept && (cmd.mode == MODE_TICK) && ended_reg)))
        else $error("result word without a tick");

    // an idle tick never reports a completion
    a_idle_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.idle && result.finished))
        else $error("idle result marked finished");

    // scan writes only ever act on returned read data
    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_SCAN)) |-> rv_reg)
        else $error("table write in scan without read data");

    // the end of the run is permanent
    a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ended_reg))
        else $error("run ended flag cleared");

    // the read counter never passes the table size
    a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_cnt_reg <= n_eff))
        else $error("scan read counter out of range");

endmodule

`default_nettype wire

// ----- rtl/pts_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
